>>> design/sptd_pkg.sv
// Package for the serial pass-through deframer.
// Holds shared constants, codes and the struct types between its modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sptd_pkg;

  // Default parameter values.
  localparam int KEY_LEN_DEF = 8;
  localparam int STR_LEN_DEF = 24;
  localparam int DEVICES_DEF = 4;

  // Command store geometry.
  localparam int STORE_DEPTH = 32;
  localparam int STORE_AW    = 5;
  localparam int COUNT_W     = STORE_AW + 1;

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_RLEN  = 2'd2;
  localparam logic [7:0] START_RST = 8'd123;
  localparam logic [7:0] END_RST   = 8'd125;
  localparam logic [7:0] RLEN_RST  = 8'd1;

  // Operating modes.
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_CMD  = 3'd1;
  localparam logic [2:0] MODE_MSG1 = 3'd2;
  localparam logic [2:0] MODE_MSG2 = 3'd3;
  localparam logic [2:0] MODE_RESP = 3'd4;

  // Input actions.
  localparam logic [1:0] ACT_HOST   = 2'd0;
  localparam logic [1:0] ACT_DEVICE = 2'd1;
  localparam logic [1:0] ACT_PRESS  = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_TO_DEV   = 3'd0;
  localparam logic [2:0] KIND_TO_HOST  = 3'd1;
  localparam logic [2:0] KIND_CMD_BYTE = 3'd2;
  localparam logic [2:0] KIND_EMPTY    = 3'd3;
  localparam logic [2:0] KIND_DEV_SEL  = 3'd4;
  localparam logic [2:0] KIND_REFUSED  = 3'd5;

  // Message characters.
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_R = 8'h52;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] response_length;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_res;
    logic [3:0] device_index;
    logic       is_key;
  } result_t;

  // Commands from the controller; each is issued only when it can complete.
  typedef struct packed {
    logic latch;
    logic settle;
    logic act;
    logic dump_emit;
    logic flush;
  } cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic set_emit;
    logic act_emit;
    logic act_dump;
    logic dump_last;
    logic dump_full;
    logic hold_valid;
    logic emit_ok;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> design/sptd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sptd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/sptd_regs.sv
// APB-style configuration registers: start byte, end byte, response length.
// Depends on sptd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sptd_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sptd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [sptd_pkg::PDATA_W-1:0] pwdata,
  output logic      [sptd_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output sptd_pkg::cfg_t                   cfg
);

  sptd_pkg::cfg_t cfg_r, cfg_nxt;
  logic [1:0]     idx;
  logic           wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        sptd_pkg::REG_START: cfg_nxt.start_byte      = pwdata[7:0];
        sptd_pkg::REG_END:   cfg_nxt.end_byte        = pwdata[7:0];
        sptd_pkg::REG_RLEN:  cfg_nxt.response_length = pwdata[7:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sptd_pkg::REG_START: prdata = {24'd0, cfg_r.start_byte};
      sptd_pkg::REG_END:   prdata = {24'd0, cfg_r.end_byte};
      sptd_pkg::REG_RLEN:  prdata = {24'd0, cfg_r.response_length};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte      <= sptd_pkg::START_RST;
      cfg_r.end_byte        <= sptd_pkg::END_RST;
      cfg_r.response_length <= sptd_pkg::RLEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/sptd_datapath.sv
// Datapath: mode and counters, command store, result staging and output register.
// Depends on sptd_pkg and sptd_ram.
`timescale 1ns / 1ps
`default_nettype none

module sptd_datapath #(
  parameter int KEY_LEN = sptd_pkg::KEY_LEN_DEF,
  parameter int STR_LEN = sptd_pkg::STR_LEN_DEF,
  parameter int DEVICES = sptd_pkg::DEVICES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire sptd_pkg::cfg_t  cfg,
  input  wire sptd_pkg::cmd_t  cmd,
  output sptd_pkg::stat_t      st,
  input  wire logic [1:0]      in_action,
  input  wire logic [7:0]      in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [2:0]           out_kind,
  output logic [7:0]           out_data_res,
  output logic [3:0]           out_device_index,
  output logic                 out_is_key,
  output logic                 out_last
);

  localparam int CW  = sptd_pkg::COUNT_W;
  localparam int AW  = sptd_pkg::STORE_AW;
  localparam int CAP = (KEY_LEN + STR_LEN > sptd_pkg::STORE_DEPTH) ?
                       sptd_pkg::STORE_DEPTH : (KEY_LEN + STR_LEN);

  logic [2:0]       mode_r, mode_nxt;
  logic [CW-1:0]    sc_r, sc_nxt;
  logic [7:0]       rl_r, rl_nxt;
  logic             press_r, press_nxt;
  logic [3:0]       nd_r, nd_nxt;
  logic [1:0]       act_r;
  logic [7:0]       dat_r;
  logic [AW-1:0]    idx_r, idx_nxt;

  logic             hold_v_r, hold_v_nxt;
  sptd_pkg::result_t hold_r, hold_nxt;
  logic             out_v_r, out_v_nxt;
  sptd_pkg::result_t out_r, out_nxt;
  logic             out_last_r, out_last_nxt;

  logic [2:0]       mode_set;
  logic             set_emit;
  logic             new_v;
  sptd_pkg::result_t new_res;
  logic             out_free;
  logic             push_hold;
  logic             is_start, is_end;
  logic             act_emit, act_dump, act_store;
  logic             dump_last;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  sptd_ram #(
    .WIDTH(8),
    .DEPTH(sptd_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(sc_r[AW-1:0]),
    .wdata(dat_r),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Settling: a drained response returns to idle, then a pending press is served.
  assign mode_set = (mode_r == sptd_pkg::MODE_RESP && rl_r == 8'd0) ?
                    sptd_pkg::MODE_IDLE : mode_r;
  assign set_emit = press_r && (mode_set == sptd_pkg::MODE_IDLE);

  assign is_start  = (dat_r == cfg.start_byte);
  assign is_end    = (dat_r == cfg.end_byte);
  assign act_dump  = (act_r == sptd_pkg::ACT_HOST) && (mode_r == sptd_pkg::MODE_CMD) &&
                     is_end && (sc_r != '0);
  assign act_store = (act_r == sptd_pkg::ACT_HOST) && (mode_r == sptd_pkg::MODE_CMD) &&
                     !is_end && (sc_r < CW'(CAP));

  always_comb begin
    act_emit = 1'b0;
    if (act_r == sptd_pkg::ACT_DEVICE) begin
      act_emit = 1'b1;
    end else if (act_r == sptd_pkg::ACT_HOST) begin
      case (mode_r)
        sptd_pkg::MODE_IDLE: act_emit = !is_start && (dat_r == sptd_pkg::CH_M);
        sptd_pkg::MODE_CMD:  act_emit = is_end && (sc_r == '0);
        default:             act_emit = 1'b1;
      endcase
    end
  end

  assign dump_last = ((CW'(idx_r) + CW'(1)) == sc_r);
  assign out_free  = !out_v_r || out_ready;

  assign st.set_emit   = set_emit;
  assign st.act_emit   = act_emit;
  assign st.act_dump   = act_dump;
  assign st.dump_last  = dump_last;
  assign st.dump_full  = (sc_r == CW'(sptd_pkg::STORE_DEPTH));
  assign st.hold_valid = hold_v_r;
  assign st.emit_ok    = !hold_v_r || out_free;
  assign st.out_free   = out_free;

  assign ram_we    = cmd.act && act_store;
  assign ram_re    = (cmd.act && act_dump) || (cmd.dump_emit && !dump_last);
  assign ram_raddr = cmd.act ? '0 : (idx_r + AW'(1));

  // State updates and the result produced by the current step.
  always_comb begin
    mode_nxt  = mode_r;
    sc_nxt    = sc_r;
    rl_nxt    = rl_r;
    press_nxt = press_r;
    nd_nxt    = nd_r;
    idx_nxt   = idx_r;
    new_v     = 1'b0;
    new_res   = '0;

    if (cmd.settle) begin
      mode_nxt = mode_set;
      if (set_emit) begin
        press_nxt = 1'b0;
        nd_nxt    = ((5'(nd_r) + 5'd1) >= 5'(DEVICES)) ? 4'd0 : (nd_r + 4'd1);
        new_v     = 1'b1;
        new_res.kind         = sptd_pkg::KIND_DEV_SEL;
        new_res.device_index = nd_r;
      end
    end

    if (cmd.act) begin
      new_v            = act_emit;
      new_res.data_res = dat_r;
      case (act_r)
        sptd_pkg::ACT_HOST: begin
          case (mode_r)
            sptd_pkg::MODE_IDLE: begin
              new_res.kind = sptd_pkg::KIND_TO_DEV;
              if (is_start) begin
                mode_nxt = sptd_pkg::MODE_CMD;
                sc_nxt   = '0;
              end else if (dat_r == sptd_pkg::CH_M) begin
                mode_nxt = sptd_pkg::MODE_MSG1;
              end
            end
            sptd_pkg::MODE_MSG1: begin
              new_res.kind = sptd_pkg::KIND_TO_DEV;
              if (dat_r == sptd_pkg::CH_T) begin
                mode_nxt = sptd_pkg::MODE_MSG2;
              end
            end
            sptd_pkg::MODE_MSG2: begin
              new_res.kind = sptd_pkg::KIND_TO_DEV;
              if (dat_r == sptd_pkg::CH_R) begin
                rl_nxt = cfg.response_length;
              end else if (dat_r == sptd_pkg::CH_T) begin
                mode_nxt = sptd_pkg::MODE_RESP;
              end
            end
            sptd_pkg::MODE_CMD: begin
              new_res.kind     = sptd_pkg::KIND_EMPTY;
              new_res.data_res = 8'd0;
              if (is_end) begin
                mode_nxt = sptd_pkg::MODE_IDLE;
                idx_nxt  = '0;
              end else if (act_store) begin
                sc_nxt = sc_r + CW'(1);
              end
            end
            default: begin
              new_res.kind = sptd_pkg::KIND_REFUSED;
            end
          endcase
        end
        sptd_pkg::ACT_DEVICE: begin
          new_res.kind = sptd_pkg::KIND_TO_HOST;
          if (rl_r != 8'd0) begin
            rl_nxt = rl_r - 8'd1;
          end
        end
        sptd_pkg::ACT_PRESS: begin
          press_nxt = 1'b1;
        end
        default: begin
          new_v = 1'b0;
        end
      endcase
    end

    if (cmd.dump_emit) begin
      new_v            = 1'b1;
      new_res.kind     = sptd_pkg::KIND_CMD_BYTE;
      new_res.data_res = ram_rdata;
      new_res.is_key   = (CW'(idx_r) < CW'(KEY_LEN));
      if (!dump_last) begin
        idx_nxt = idx_r + AW'(1);
      end
    end
  end

  // A result is staged in the hold register until the next one shows whether it is last.
  assign push_hold = hold_v_r && (new_v || cmd.flush);

  always_comb begin
    hold_v_nxt   = hold_v_r;
    hold_nxt     = hold_r;
    out_v_nxt    = out_v_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    if (push_hold) begin
      out_v_nxt    = 1'b1;
      out_nxt      = hold_r;
      out_last_nxt = cmd.flush;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (new_v) begin
      hold_v_nxt = 1'b1;
      hold_nxt   = new_res;
    end else if (cmd.flush) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= sptd_pkg::MODE_IDLE;
      sc_r     <= '0;
      rl_r     <= 8'd0;
      press_r  <= 1'b0;
      nd_r     <= 4'd0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      sc_r     <= sc_nxt;
      rl_r     <= rl_nxt;
      press_r  <= press_nxt;
      nd_r     <= nd_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r <= in_action;
      dat_r <= in_data;
    end
    idx_r      <= idx_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_v_r;
  assign out_kind         = out_r.kind;
  assign out_data_res     = out_r.data_res;
  assign out_device_index = out_r.device_index;
  assign out_is_key       = out_r.is_key;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

>>> design/sptd_ctrl.sv
// Controller state machine: sequences settle, action, store dump and flush per item.
// Depends on sptd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sptd_ctrl (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire sptd_pkg::stat_t st,
  output sptd_pkg::cmd_t  cmd
);

  localparam logic [2:0] C_WAIT  = 3'd0;
  localparam logic [2:0] C_SET1  = 3'd1;
  localparam logic [2:0] C_ACT   = 3'd2;
  localparam logic [2:0] C_DUMP  = 3'd3;
  localparam logic [2:0] C_SET2  = 3'd4;
  localparam logic [2:0] C_FLUSH = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == C_WAIT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      C_WAIT: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = C_SET1;
        end
      end
      C_SET1: begin
        if (!st.set_emit || st.emit_ok) begin
          cmd.settle = 1'b1;
          state_nxt  = C_ACT;
        end
      end
      C_ACT: begin
        if (st.act_dump) begin
          cmd.act   = 1'b1;
          state_nxt = C_DUMP;
        end else if (!st.act_emit || st.emit_ok) begin
          cmd.act   = 1'b1;
          state_nxt = C_SET2;
        end
      end
      C_DUMP: begin
        if (st.emit_ok) begin
          cmd.dump_emit = 1'b1;
          if (st.dump_last) begin
            // A full store fills the result budget, so the closing settle is skipped.
            state_nxt = st.dump_full ? C_FLUSH : C_SET2;
          end
        end
      end
      C_SET2: begin
        if (!st.set_emit || st.emit_ok) begin
          cmd.settle = 1'b1;
          state_nxt  = C_FLUSH;
        end
      end
      C_FLUSH: begin
        if (!st.hold_valid) begin
          state_nxt = C_WAIT;
        end else if (st.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = C_WAIT;
        end
      end
      default: begin
        state_nxt = C_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/serial_passthrough_deframer.sv
// Top level of the serial pass-through deframer.
// Depends on sptd_pkg, sptd_regs, sptd_ctrl, sptd_datapath and sptd_ram.
//
// The input channel carries one event per item: a host byte, a device byte or
// a button press (in_action, in_data). The result channel carries zero or more
// items per input item; out_last marks the final result of each input item.
// Device bytes are always forwarded to the host. Host bytes are captured as
// a command between the start and end bytes, forwarded as a message to the
// device, or refused while a read response is still outstanding. A press is
// held pending and answered in idle with the next device index.
//
// Sequencing: the controller takes one item at a time and walks it through the
// steps accept, settle, act, settle and flush; a command dump adds a step per
// stored byte and, for a full 32-byte store, replaces the closing settle. The
// dump is paced by the single read port of the command store. Each result is
// staged in the hold register before it reaches the output register.
// When the receiver stalls, the output register holds and the controller waits
// at the next result; no result is dropped. Synchronous reset returns the
// mode to idle, clears the store count, response length and device counter,
// the pending press and the hold and output valid flags, and loads the
// register defaults; the dump index and the command store are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module serial_passthrough_deframer #(
  parameter int KEY_LEN = sptd_pkg::KEY_LEN_DEF,
  parameter int STR_LEN = sptd_pkg::STR_LEN_DEF,
  parameter int DEVICES = sptd_pkg::DEVICES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input channel.
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_action,
  input  wire logic [7:0]                   in_data,
  // Result channel.
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [2:0]                   out_kind,
  output logic      [7:0]                   out_data_res,
  output logic      [3:0]                   out_device_index,
  output logic                              out_is_key,
  output logic                              out_last,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sptd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [sptd_pkg::PDATA_W-1:0] pwdata,
  output logic      [sptd_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);

  sptd_pkg::cfg_t  cfg;
  sptd_pkg::cmd_t  cmd;
  sptd_pkg::stat_t st;

  // Register file; the user must change values only while the block is idle; the block does not enforce it.
  sptd_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // The controller walks each item through its steps and stalls on a busy output.
  sptd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  // The datapath owns the mode, counters, command store and output staging.
  sptd_datapath #(
    .KEY_LEN(KEY_LEN),
    .STR_LEN(STR_LEN),
    .DEVICES(DEVICES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .st              (st),
    .in_action       (in_action),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_data_res    (out_data_res),
    .out_device_index(out_device_index),
    .out_is_key      (out_is_key),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

>>> design/sptd_checker.sv
// Port-level checker for the serial pass-through deframer, with its bind.
// Depends on sptd_pkg and serial_passthrough_deframer.
`timescale 1ns / 1ps
`default_nettype none

module sptd_checker #(
  parameter int DEVICES = sptd_pkg::DEVICES_DEF
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_kind,
  input wire logic [7:0] out_data_res,
  input wire logic [3:0] out_device_index,
  input wire logic       out_is_key,
  input wire logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_data_res) && $stable(out_device_index) && $stable(out_last))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= sptd_pkg::KIND_REFUSED)
    else $error("result kind out of range");

  a_key_only_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != sptd_pkg::KIND_CMD_BYTE |-> !out_is_key)
    else $error("key flag on a non-command result");

  a_dev_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == sptd_pkg::KIND_DEV_SEL |-> out_data_res == 8'd0 &&
      32'(out_device_index) < DEVICES)
    else $error("bad device select result");

  a_dev_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != sptd_pkg::KIND_DEV_SEL |-> out_device_index == 4'd0)
    else $error("device index on a non-select result");

endmodule

bind serial_passthrough_deframer sptd_checker #(.DEVICES(DEVICES)) u_sptd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .out_data_res    (out_data_res),
  .out_device_index(out_device_index),
  .out_is_key      (out_is_key),
  .out_last        (out_last)
);

`default_nettype wire
